// ----- sv/ccr_pkg.sv -----
package ccr_pkg;

  localparam int CARD_SLOTS  = 4;
  localparam int MAX_COLUMNS = 82;
  localparam int DATA_BITS   = 12;

  localparam int SLOT_W      = (CARD_SLOTS > 1) ? $clog2(CARD_SLOTS) : 1;
  localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
  localparam int STORE_DEPTH = CARD_SLOTS * MAX_COLUMNS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int OP_W        = 3;
  localparam int PIN_W       = 12;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_STROBE    = 3'd0,
    OP_CARD_END  = 3'd1,
    OP_HOOK      = 3'd2,
    OP_READ      = 3'd3,
    OP_PICK_ONE  = 3'd4,
    OP_PICK_CONT = 3'd5,
    OP_CONT_OFF  = 3'd6,
    OP_RESET     = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE    = 3'd0,
    ST_COLUMN  = 3'd1,
    ST_NO_CARD = 3'd2,
    ST_OVERRUN = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_t;

  typedef struct packed {
    logic accept;
    logic load_rd;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_is_read;
  } dp_sts_t;

endpackage

// ----- sv/card_column_capture_ring.sv -----
// a non-read beat goes straight into the output register; a read column first passes
// through the registered read of the column store and then the output register
// throughput: one beat per cycle while the output is free; a read holds in_tready low while it completes
// rst_n clears the ring pointers, card lengths, flags and count, pick released;
// the column store keeps its contents and needs no clearing pass
module card_column_capture_ring
  import ccr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // column_pins[11:0]
  input  logic [OP_W-1:0]        in_tuser,   // operation[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // column_data[11:0], pick_line[12],
                                             // continuous_pick[13], overrun_flag[14],
                                             // cards_counted[30:15]
  output logic [STATUS_W-1:0]    out_tuser,  // status[2:0]
  output logic                   out_tlast   // last_of_card
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic [PIN_W-1:0]   data_w;
  logic               pick_w;
  logic               cont_w;
  logic               overrun_w;
  logic [COUNT_W-1:0] count_w;

  ccr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_op       (in_tuser),
    .in_pins     (in_tdata[PIN_W-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_status  (out_tuser),
    .out_data    (data_w),
    .out_last    (out_tlast),
    .out_pick    (pick_w),
    .out_cont    (cont_w),
    .out_overrun (overrun_w),
    .out_count   (count_w)
  );

  assign out_tdata = {1'b0, count_w, overrun_w, cont_w, pick_w, data_w};

endmodule

// ----- sv/ccr_ctrl.sv -----
module ccr_ctrl
  import ccr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  fsm_t state_r;
  fsm_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_tvalid && sts.out_free && sts.in_is_read) begin
          state_nxt = FSM_READ;
        end
      end
      FSM_READ: begin
        state_nxt = FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.accept  = 1'b0;
    cmd.load_rd = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        in_tready  = sts.out_free;
        cmd.accept = sts.out_free && in_tvalid;
      end
      FSM_READ: begin
        cmd.load_rd = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/ccr_dp.sv -----
module ccr_dp
  import ccr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [OP_W-1:0]        in_op,
  input  logic [PIN_W-1:0]       in_pins,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [STATUS_W-1:0]    out_status,
  output logic [PIN_W-1:0]       out_data,
  output logic                   out_last,
  output logic                   out_pick,
  output logic                   out_cont,
  output logic                   out_overrun,
  output logic [COUNT_W-1:0]     out_count
);

  logic [DATA_BITS-1:0] store_mem [STORE_DEPTH];
  logic [DATA_BITS-1:0] store_q_r;

  logic [COL_W-1:0]   lens_r [CARD_SLOTS];
  logic [COL_W-1:0]   wr_len_r, wr_len_nxt;
  logic [SLOT_W-1:0]  wr_card_r, wr_card_nxt;
  logic [SLOT_W-1:0]  rd_card_r, rd_card_nxt;
  logic [COL_W-1:0]   rd_col_r, rd_col_nxt;
  logic               overrun_r, overrun_nxt;
  logic               cont_r, cont_nxt;
  logic               pick_r, pick_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               commit_len;
  logic               clear_lens;
  logic               store_we;
  logic [ADDR_W-1:0]  store_waddr;
  logic [ADDR_W-1:0]  store_raddr;
  logic               store_re;

  logic [STATUS_W-1:0] rd_status_r, rd_status_nxt;
  logic                rd_last_r, rd_last_nxt;

  logic               out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PIN_W-1:0]   out_data_r;
  logic               out_last_r;
  logic               out_pick_r;
  logic               out_cont_r;
  logic               out_overrun_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [SLOT_W-1:0]  wr_next_slot;
  logic [SLOT_W-1:0]  rd_next_slot;
  logic [COL_W-1:0]   rd_len;
  logic [COL_W-1:0]   rd_pos;
  logic [COL_W:0]     rd_pos_inc;
  op_t                op;

  assign op = op_t'(in_op);
  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.in_is_read = (op == OP_READ);

  assign wr_next_slot = (wr_card_r == SLOT_W'(CARD_SLOTS - 1)) ? '0 : wr_card_r + 1'b1;
  assign rd_next_slot = (rd_card_r == SLOT_W'(CARD_SLOTS - 1)) ? '0 : rd_card_r + 1'b1;
  assign rd_len       = lens_r[rd_card_r];
  assign rd_pos       = (rd_col_r >= rd_len) ? rd_len - 1'b1 : rd_col_r;
  assign rd_pos_inc   = {1'b0, rd_pos} + 1'b1;

  assign store_waddr = ADDR_W'(wr_card_r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(wr_len_r);
  assign store_raddr = ADDR_W'(rd_card_r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(rd_pos);

  always_comb begin
    wr_len_nxt    = wr_len_r;
    wr_card_nxt   = wr_card_r;
    rd_card_nxt   = rd_card_r;
    rd_col_nxt    = rd_col_r;
    overrun_nxt   = overrun_r;
    cont_nxt      = cont_r;
    pick_nxt      = pick_r;
    count_nxt     = count_r;
    rd_status_nxt = rd_status_r;
    rd_last_nxt   = rd_last_r;
    commit_len    = 1'b0;
    clear_lens    = 1'b0;
    store_we      = 1'b0;
    store_re      = 1'b0;
    if (cmd.accept) begin
      case (op)
        OP_STROBE: begin
          if (wr_len_r < COL_W'(MAX_COLUMNS)) begin
            store_we   = 1'b1;
            wr_len_nxt = wr_len_r + 1'b1;
          end
        end
        OP_CARD_END: begin
          if (!cont_r) begin
            pick_nxt = 1'b1;
          end
          if (wr_next_slot == rd_card_r) begin
            overrun_nxt = 1'b1;
          end else begin
            commit_len  = 1'b1;
            wr_card_nxt = wr_next_slot;
            wr_len_nxt  = '0;
          end
          if (count_r != '1) begin
            count_nxt = count_r + 1'b1;
          end
        end
        OP_HOOK: begin
          pick_nxt = 1'b1;
          cont_nxt = 1'b0;
        end
        OP_READ: begin
          rd_last_nxt = 1'b0;
          if (overrun_r) begin
            rd_status_nxt = ST_OVERRUN;
          end else if (wr_card_r == rd_card_r) begin
            rd_status_nxt = ST_NO_CARD;
          end else if (rd_len == '0) begin
            rd_status_nxt = ST_EMPTY;
            rd_last_nxt   = 1'b1;
            rd_card_nxt   = rd_next_slot;
            rd_col_nxt    = '0;
          end else begin
            rd_status_nxt = ST_COLUMN;
            store_re      = 1'b1;
            if (rd_pos_inc >= {1'b0, rd_len}) begin
              rd_last_nxt = 1'b1;
              rd_card_nxt = rd_next_slot;
              rd_col_nxt  = '0;
            end else begin
              rd_col_nxt = rd_pos_inc[COL_W-1:0];
            end
          end
        end
        OP_PICK_ONE: begin
          pick_nxt  = 1'b0;
          count_nxt = '0;
          cont_nxt  = 1'b0;
        end
        OP_PICK_CONT: begin
          pick_nxt  = 1'b0;
          count_nxt = '0;
          cont_nxt  = 1'b1;
        end
        OP_CONT_OFF: begin
          cont_nxt = 1'b0;
        end
        OP_RESET: begin
          clear_lens  = 1'b1;
          wr_len_nxt  = '0;
          wr_card_nxt = '0;
          rd_card_nxt = '0;
          rd_col_nxt  = '0;
          overrun_nxt = 1'b0;
          cont_nxt    = 1'b0;
          pick_nxt    = 1'b1;
          count_nxt   = '0;
        end
        default: begin
          cont_nxt = cont_r;
        end
      endcase
    end
  end

  // column store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= DATA_BITS'(~in_pins);
    end
    if (store_re) begin
      store_q_r <= store_mem[store_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CARD_SLOTS; i++) begin
        lens_r[i] <= '0;
      end
      wr_len_r    <= '0;
      wr_card_r   <= '0;
      rd_card_r   <= '0;
      rd_col_r    <= '0;
      overrun_r   <= 1'b0;
      cont_r      <= 1'b0;
      pick_r      <= 1'b1;
      count_r     <= '0;
      rd_status_r <= ST_NONE;
      rd_last_r   <= 1'b0;
    end else begin
      if (clear_lens) begin
        for (int i = 0; i < CARD_SLOTS; i++) begin
          lens_r[i] <= '0;
        end
      end else if (commit_len) begin
        lens_r[wr_card_r] <= wr_len_r;
      end
      wr_len_r    <= wr_len_nxt;
      wr_card_r   <= wr_card_nxt;
      rd_card_r   <= rd_card_nxt;
      rd_col_r    <= rd_col_nxt;
      overrun_r   <= overrun_nxt;
      cont_r      <= cont_nxt;
      pick_r      <= pick_nxt;
      count_r     <= count_nxt;
      rd_status_r <= rd_status_nxt;
      rd_last_r   <= rd_last_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_rd || (cmd.accept && op != OP_READ)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      out_status_r  <= rd_status_r;
      out_data_r    <= (rd_status_r == ST_COLUMN) ? PIN_W'(store_q_r) : '0;
      out_last_r    <= rd_last_r;
      out_pick_r    <= pick_r;
      out_cont_r    <= cont_r;
      out_overrun_r <= overrun_r;
      out_count_r   <= count_r;
    end else if (cmd.accept && op != OP_READ) begin
      out_status_r  <= ST_NONE;
      out_data_r    <= '0;
      out_last_r    <= 1'b0;
      out_pick_r    <= pick_nxt;
      out_cont_r    <= cont_nxt;
      out_overrun_r <= overrun_nxt;
      out_count_r   <= count_nxt;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_status  = out_status_r;
  assign out_data    = out_data_r;
  assign out_last    = out_last_r;
  assign out_pick    = out_pick_r;
  assign out_cont    = out_cont_r;
  assign out_overrun = out_overrun_r;
  assign out_count   = out_count_r;

endmodule

// ----- tb/tb_card_column_capture_ring.sv -----
`timescale 1ns / 1ps

module tb_card_column_capture_ring
  import ccr_pkg::*;
();

  localparam int STUCK_LIMIT  = 1000;
  localparam int RANDOM_BEATS = 400;
  localparam int TAIL_CYCLES  = 8;

  typedef struct packed {
    status_t              status;
    logic [DATA_BITS-1:0] data;
    logic                 last;
    logic                 pick;
    logic                 cont;
    logic                 ovr;
    logic [COUNT_W-1:0]   count;
  } ring_beat_t;

  typedef struct {
    op_t              op;
    logic [PIN_W-1:0] pins;
    int               reps;
    bit               typed;
    ring_beat_t       want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = OP_STROBE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tlast;

  card_column_capture_ring u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the ring
  logic [DATA_BITS-1:0] ring_store [STORE_DEPTH];
  logic [COL_W-1:0]     ring_len   [CARD_SLOTS];
  logic [SLOT_W-1:0]    ring_wr;
  logic [SLOT_W-1:0]    ring_rd;
  logic [COL_W-1:0]     ring_col;
  logic                 ring_ovr;
  logic                 ring_cont;
  logic                 ring_pick;
  logic [COUNT_W-1:0]   ring_count;

  ring_beat_t pending_beats [$];
  dir_row_t   dir_rows [$];

  int mismatch_cnt = 0;
  int beats_in     = 0;
  int beats_out    = 0;
  int burst_left   = 0;
  int n_column     = 0;
  int n_empty      = 0;
  int n_no_card    = 0;
  int n_overrun    = 0;
  int stall_mode   = 0;
  int stall_left   = 0;
  int stuck_cycles = 0;

  function automatic logic [SLOT_W-1:0] slot_after(logic [SLOT_W-1:0] s);
    return SLOT_W'((int'(s) + 1) % CARD_SLOTS);
  endfunction

  function automatic void ring_clear();
    for (int i = 0; i < CARD_SLOTS; i++) ring_len[i] = '0;
    ring_wr    = '0;
    ring_rd    = '0;
    ring_col   = '0;
    ring_ovr   = 1'b0;
    ring_cont  = 1'b0;
    ring_pick  = 1'b1;
    ring_count = '0;
  endfunction

  function automatic ring_beat_t ring_predict(op_t op, logic [PIN_W-1:0] pins);
    ring_beat_t b;
    int len;
    int col;
    b.status = ST_NONE;
    b.data   = '0;
    b.last   = 1'b0;
    case (op)
      OP_STROBE: begin
        len = int'(ring_len[ring_wr]);
        if (len < MAX_COLUMNS) begin
          ring_store[int'(ring_wr) * MAX_COLUMNS + len] = ~pins[DATA_BITS-1:0];
          ring_len[ring_wr] = COL_W'(len + 1);
        end
      end
      OP_CARD_END: begin
        if (!ring_cont) ring_pick = 1'b1;
        if (slot_after(ring_wr) == ring_rd) begin
          ring_ovr = 1'b1;
        end else begin
          ring_wr = slot_after(ring_wr);
          ring_len[ring_wr] = '0;
        end
        if (ring_count != '1) ring_count = ring_count + 1'b1;
      end
      OP_HOOK: begin
        ring_pick = 1'b1;
        ring_cont = 1'b0;
      end
      OP_READ: begin
        if (ring_ovr) begin
          b.status = ST_OVERRUN;
        end else if (ring_wr == ring_rd) begin
          b.status = ST_NO_CARD;
        end else begin
          len = int'(ring_len[ring_rd]);
          if (len == 0) begin
            b.status = ST_EMPTY;
            b.last   = 1'b1;
            ring_rd  = slot_after(ring_rd);
            ring_col = '0;
          end else begin
            col = int'(ring_col);
            if (col >= len) col = len - 1;
            b.status = ST_COLUMN;
            b.data   = ring_store[int'(ring_rd) * MAX_COLUMNS + col];
            if (col + 1 >= len) begin
              b.last   = 1'b1;
              ring_rd  = slot_after(ring_rd);
              ring_col = '0;
            end else begin
              ring_col = COL_W'(col + 1);
            end
          end
        end
      end
      OP_PICK_ONE: begin
        ring_pick  = 1'b0;
        ring_count = '0;
        ring_cont  = 1'b0;
      end
      OP_PICK_CONT: begin
        ring_pick  = 1'b0;
        ring_count = '0;
        ring_cont  = 1'b1;
      end
      OP_CONT_OFF: ring_cont = 1'b0;
      default: ring_clear();
    endcase
    b.pick  = ring_pick;
    b.cont  = ring_cont;
    b.ovr   = ring_ovr;
    b.count = ring_count;
    return b;
  endfunction

  task automatic add_row(op_t op, logic [PIN_W-1:0] pins, int reps, bit typed,
                         status_t st, logic [DATA_BITS-1:0] d, logic l, logic p,
                         logic c, logic o, logic [COUNT_W-1:0] n);
    dir_row_t r;
    r.op   = op;
    r.pins = pins;
    r.reps = reps;
    r.typed = typed;
    r.want = '{st, d, l, p, c, o, n};
    dir_rows.push_back(r);
  endtask

  task automatic send_beat(op_t op, logic [PIN_W-1:0] pins, bit typed, ring_beat_t want);
    ring_beat_t pred;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'(pins);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = ring_predict(op, pins);
    pending_beats.push_back(typed ? want : pred);
    burst_left--;
    beats_in++;
  endtask

  task automatic drain_ring();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // receiver backpressure, picks a new random mode each time its countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 7) != 0);
      default: out_tready <= ((stall_left % 8) == 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    ring_beat_t got;
    ring_beat_t w;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tuser);
      got.data   = out_tdata[DATA_BITS-1:0];
      got.last   = out_tlast;
      got.pick   = out_tdata[12];
      got.cont   = out_tdata[13];
      got.ovr    = out_tdata[14];
      got.count  = out_tdata[30:15];
      beats_out++;
      case (got.status)
        ST_COLUMN:  n_column++;
        ST_EMPTY:   n_empty++;
        ST_NO_CARD: n_no_card++;
        ST_OVERRUN: n_overrun++;
        default: ;
      endcase
      if (pending_beats.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected beat: st=%0d d=%h last=%b pick=%b cont=%b ovr=%b cnt=%0d",
                   got.status, got.data, got.last, got.pick, got.cont, got.ovr, got.count);
      end else begin
        w = pending_beats.pop_front();
        if (got.status !== w.status || got.data !== w.data || got.last !== w.last ||
            got.pick !== w.pick || got.cont !== w.cont || got.ovr !== w.ovr ||
            got.count !== w.count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch at beat %0d: want st=%0d d=%h last=%b pick=%b cont=%b ovr=%b cnt=%0d",
                     beats_out, w.status, w.data, w.last, w.pick, w.cont, w.ovr, w.count);
            $display("                      got  st=%0d d=%h last=%b pick=%b cont=%b ovr=%b cnt=%0d",
                     got.status, got.data, got.last, got.pick, got.cont, got.ovr, got.count);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 STUCK_LIMIT, pending_beats.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int start_beats;
    int dir_beats;
    int sel;
    int n;
    ring_clear();

    // directed rows
    add_row(OP_READ,      12'h000, 1, 1, ST_NO_CARD, 12'h000, 0, 1, 0, 0, 16'd0);
    add_row(OP_STROBE,    12'h000, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 0, 16'd0);
    add_row(OP_STROBE,    12'hFFF, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 0, 16'd0);
    add_row(OP_STROBE,    12'hA5A, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 0, 16'd0);
    add_row(OP_CARD_END,  12'h000, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 0, 16'd1);
    add_row(OP_READ,      12'h000, 1, 1, ST_COLUMN,  12'hFFF, 0, 1, 0, 0, 16'd1);
    add_row(OP_READ,      12'hFFF, 1, 1, ST_COLUMN,  12'h000, 0, 1, 0, 0, 16'd1);
    add_row(OP_READ,      12'h000, 1, 1, ST_COLUMN,  12'h5A5, 1, 1, 0, 0, 16'd1);
    add_row(OP_READ,      12'h000, 1, 1, ST_NO_CARD, 12'h000, 0, 1, 0, 0, 16'd1);
    add_row(OP_PICK_ONE,  12'h000, 1, 1, ST_NONE,    12'h000, 0, 0, 0, 0, 16'd0);
    add_row(OP_CARD_END,  12'h000, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 0, 16'd1);
    add_row(OP_READ,      12'h000, 1, 1, ST_EMPTY,   12'h000, 1, 1, 0, 0, 16'd1);
    add_row(OP_PICK_CONT, 12'h000, 1, 1, ST_NONE,    12'h000, 0, 0, 1, 0, 16'd0);
    add_row(OP_CARD_END,  12'h000, 1, 1, ST_NONE,    12'h000, 0, 0, 1, 0, 16'd1);
    add_row(OP_CONT_OFF,  12'h000, 1, 1, ST_NONE,    12'h000, 0, 0, 0, 0, 16'd1);
    add_row(OP_HOOK,      12'h000, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 0, 16'd1);
    add_row(OP_CARD_END,  12'h000, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 0, 16'd2);
    add_row(OP_CARD_END,  12'h000, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 0, 16'd3);
    // ring full
    add_row(OP_CARD_END,  12'h000, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 1, 16'd4);
    add_row(OP_STROBE,    12'h3C3, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 1, 16'd4);
    add_row(OP_READ,      12'h000, 1, 1, ST_OVERRUN, 12'h000, 0, 1, 0, 1, 16'd4);
    add_row(OP_RESET,     12'h000, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 0, 16'd0);
    // one column past the limit, then read the full card back
    add_row(OP_STROBE,    12'h0F0, MAX_COLUMNS + 1, 0, ST_NONE, 12'h000, 0, 0, 0, 0, 16'd0);
    add_row(OP_CARD_END,  12'h000, 1, 0, ST_NONE,    12'h000, 0, 0, 0, 0, 16'd0);
    add_row(OP_READ,      12'h000, MAX_COLUMNS, 0, ST_NONE, 12'h000, 0, 0, 0, 0, 16'd0);
    add_row(OP_READ,      12'h000, 1, 1, ST_NO_CARD, 12'h000, 0, 1, 0, 0, 16'd1);
    // fill the ring past full from a shifted start, then clear
    add_row(OP_CARD_END,  12'h000, 4, 0, ST_NONE,    12'h000, 0, 0, 0, 0, 16'd0);
    add_row(OP_READ,      12'h000, 1, 1, ST_OVERRUN, 12'h000, 0, 1, 0, 1, 16'd5);
    add_row(OP_PICK_ONE,  12'h000, 1, 1, ST_NONE,    12'h000, 0, 0, 0, 1, 16'd0);
    add_row(OP_RESET,     12'h000, 1, 1, ST_NONE,    12'h000, 0, 1, 0, 0, 16'd0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++)
        send_beat(dir_rows[i].op, dir_rows[i].pins ^ PIN_W'(k),
                  dir_rows[i].typed && (k == dir_rows[i].reps - 1), dir_rows[i].want);
    end
    drain_ring();
    dir_beats = beats_in;

    // random cards, reads and pick commands with some noise
    start_beats = beats_in;
    while (beats_in - start_beats < RANDOM_BEATS) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_COLUMNS - 4, MAX_COLUMNS + 4)
                                         : $urandom_range(0, 6);
        for (int k = 0; k < n; k++)
          send_beat(OP_STROBE, PIN_W'($urandom), 1'b0, '0);
        send_beat(OP_CARD_END, PIN_W'($urandom), 1'b0, '0);
      end else if (sel < 75) begin
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++)
          send_beat(OP_READ, PIN_W'($urandom), 1'b0, '0);
      end else if (sel < 88) begin
        case ($urandom_range(0, 3))
          0:       send_beat(OP_PICK_ONE,  PIN_W'($urandom), 1'b0, '0);
          1:       send_beat(OP_PICK_CONT, PIN_W'($urandom), 1'b0, '0);
          2:       send_beat(OP_CONT_OFF,  PIN_W'($urandom), 1'b0, '0);
          default: send_beat(OP_HOOK,      PIN_W'($urandom), 1'b0, '0);
        endcase
      end else if (sel < 92) begin
        send_beat(OP_RESET, PIN_W'($urandom), 1'b0, '0);
      end else if (sel < 98) begin
        send_beat(op_t'($urandom_range(0, 7)), PIN_W'($urandom), 1'b0, '0);
      end else begin
        drain_ring();
      end
    end

    drain_ring();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d directed and %0d random beats in, %0d results out",
             dir_beats, beats_in - dir_beats, beats_out);
    $display("reads: %0d columns, %0d empty cards, %0d with no card, %0d during overrun",
             n_column, n_empty, n_no_card, n_overrun);
    if (mismatch_cnt == 0 && pending_beats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, pending_beats.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
